[rtl/dnsrp_pkg.sv]
package dnsrp_pkg;

  typedef enum logic [3:0] {
    PH_HEADER     = 4'd0,
    PH_NAME_LEN   = 4'd1,
    PH_NAME_LABEL = 4'd2,
    PH_NAME_PTR   = 4'd3,
    PH_QTYPE      = 4'd4,
    PH_QCLASS     = 4'd5,
    PH_ATYPE      = 4'd6,
    PH_ACLASS     = 4'd7,
    PH_TTL        = 4'd8,
    PH_RDLEN      = 4'd9,
    PH_ADATA      = 4'd10,
    PH_CSKIP      = 4'd11
  } phase_t;

  localparam logic [3:0] ST_FOUND      = 4'd0;
  localparam logic [3:0] ST_BAD_ID     = 4'd1;
  localparam logic [3:0] ST_BAD_FLAGS  = 4'd2;
  localparam logic [3:0] ST_NO_ANSWERS = 4'd3;
  localparam logic [3:0] ST_BAD_QUEST  = 4'd4;
  localparam logic [3:0] ST_BAD_ACLASS = 4'd5;
  localparam logic [3:0] ST_BAD_ALEN   = 4'd6;
  localparam logic [3:0] ST_BAD_ATYPE  = 4'd7;
  localparam logic [3:0] ST_NO_A       = 4'd8;

  localparam logic [15:0] FLAG_QR       = 16'h8000;
  localparam logic [15:0] FLAG_RD       = 16'h0100;
  localparam logic [15:0] FLAG_RA       = 16'h0080;
  localparam logic [15:0] FLAGS_NEED    = FLAG_QR | FLAG_RD | FLAG_RA;
  localparam logic [15:0] RR_TYPE_A     = 16'h0001;
  localparam logic [15:0] RR_TYPE_CNAME = 16'h0005;
  localparam logic [15:0] RR_CLASS_IN   = 16'h0001;
  localparam logic [15:0] A_DATA_LEN    = 16'd4;
  localparam logic [7:0]  NAME_PTR_BITS = 8'hc0;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  byte_cnt;
    logic [15:0] shift;
    logic [15:0] questions_left;
    logic [15:0] answers_left;
    logic [15:0] skip_left;
    logic        decided;
    logic [3:0]  held_status;
    logic [31:0] found_address;
  } parse_state_t;

  localparam parse_state_t PARSE_CLEAR = '{
    phase:          PH_HEADER,
    byte_cnt:       4'd0,
    shift:          16'd0,
    questions_left: 16'd0,
    answers_left:   16'd0,
    skip_left:      16'd0,
    decided:        1'b0,
    held_status:    4'd0,
    found_address:  32'd0
  };

endpackage

[rtl/dnsrp_if.sv]
interface dnsrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source(output valid, rx_byte, last_byte, input ready);
  modport sink(input valid, rx_byte, last_byte, output ready);
endinterface

interface dnsrp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] address;

  modport source(output valid, status, address, input ready);
  modport sink(input valid, status, address, output ready);
endinterface

[rtl/dnsrp_step.sv]
module dnsrp_step (
  input  dnsrp_pkg::parse_state_t cur,
  input  logic [7:0]              rx_byte,
  input  logic [15:0]             expected_id,
  output dnsrp_pkg::parse_state_t nxt
);
  import dnsrp_pkg::*;

  function automatic parse_state_t enter_field(parse_state_t st, phase_t ph);
    parse_state_t r;
    r = st;
    r.phase = ph;
    r.byte_cnt = 4'd0;
    r.shift = 16'd0;
    return r;
  endfunction

  function automatic parse_state_t decide(parse_state_t st, logic [3:0] code);
    parse_state_t r;
    r = st;
    r.decided = 1'b1;
    r.held_status = code;
    return r;
  endfunction

  function automatic parse_state_t name_done(parse_state_t st);
    if (st.questions_left != 16'd0) return enter_field(st, PH_QTYPE);
    return enter_field(st, PH_ATYPE);
  endfunction

  function automatic parse_state_t answer_done(parse_state_t st);
    parse_state_t r;
    r = st;
    r.answers_left = st.answers_left - 16'd1;
    if (r.answers_left == 16'd0) begin
      r = decide(r, ST_NO_A);
    end else begin
      r = enter_field(r, PH_NAME_LEN);
    end
    return r;
  endfunction

  parse_state_t s;

  always_comb begin
    s = cur;
    if (!cur.decided) begin
      s.shift = {cur.shift[7:0], rx_byte};
      s.byte_cnt = cur.byte_cnt + 4'd1;
      case (cur.phase)
        PH_HEADER: begin
          if (s.byte_cnt == 4'd2 && s.shift != expected_id) begin
            s = decide(s, ST_BAD_ID);
          end else if (s.byte_cnt == 4'd4) begin
            if ((s.shift & FLAGS_NEED) != FLAGS_NEED) s = decide(s, ST_BAD_FLAGS);
          end else if (s.byte_cnt == 4'd6) begin
            s.questions_left = s.shift;
          end else if (s.byte_cnt == 4'd8) begin
            s.answers_left = s.shift;
            if (s.shift == 16'd0) s = decide(s, ST_NO_ANSWERS);
          end else if (s.byte_cnt == 4'd12) begin
            s = enter_field(s, PH_NAME_LEN);
          end
        end
        PH_NAME_LEN: begin
          s.byte_cnt = 4'd0;
          if (rx_byte == 8'd0) begin
            s = name_done(s);
          end else if ((rx_byte & NAME_PTR_BITS) == NAME_PTR_BITS) begin
            s.phase = PH_NAME_PTR;
          end else begin
            s.skip_left = {8'd0, rx_byte};
            s.phase = PH_NAME_LABEL;
          end
        end
        PH_NAME_LABEL: begin
          s.byte_cnt = 4'd0;
          s.skip_left = cur.skip_left - 16'd1;
          if (s.skip_left == 16'd0) s.phase = PH_NAME_LEN;
        end
        PH_NAME_PTR: begin
          s = name_done(s);
        end
        PH_QTYPE: begin
          if (s.byte_cnt == 4'd2) begin
            if (s.shift != RR_TYPE_A) s = decide(s, ST_BAD_QUEST);
            else s = enter_field(s, PH_QCLASS);
          end
        end
        PH_QCLASS: begin
          if (s.byte_cnt == 4'd2) begin
            if (s.shift != RR_CLASS_IN) begin
              s = decide(s, ST_BAD_QUEST);
            end else begin
              s.questions_left = cur.questions_left - 16'd1;
              s = enter_field(s, PH_NAME_LEN);
            end
          end
        end
        PH_ATYPE: begin
          if (s.byte_cnt == 4'd2) begin
            s.skip_left = s.shift;  // record type
            s = enter_field(s, PH_ACLASS);
          end
        end
        PH_ACLASS: begin
          if (s.byte_cnt == 4'd2) begin
            if (s.shift != RR_CLASS_IN) s = decide(s, ST_BAD_ACLASS);
            else s = enter_field(s, PH_TTL);
          end
        end
        PH_TTL: begin
          if (s.byte_cnt == 4'd4) begin
            if (cur.skip_left != RR_TYPE_A && cur.skip_left != RR_TYPE_CNAME)
              s = decide(s, ST_BAD_ATYPE);
            else
              s = enter_field(s, PH_RDLEN);
          end
        end
        PH_RDLEN: begin
          if (s.byte_cnt == 4'd2) begin
            if (cur.skip_left == RR_TYPE_A) begin
              if (s.shift != A_DATA_LEN) begin
                s = decide(s, ST_BAD_ALEN);
              end else begin
                s.found_address = 32'd0;
                s = enter_field(s, PH_ADATA);
              end
            end else if (s.shift == 16'd0) begin
              s = answer_done(s);
            end else begin
              s.skip_left = s.shift;
              s = enter_field(s, PH_CSKIP);
            end
          end
        end
        PH_ADATA: begin
          s.found_address = {cur.found_address[23:0], rx_byte};
          if (s.byte_cnt == 4'd4) s = decide(s, ST_FOUND);
        end
        PH_CSKIP: begin
          s.byte_cnt = 4'd0;
          s.skip_left = cur.skip_left - 16'd1;
          if (s.skip_left == 16'd0) s = answer_done(s);
        end
        default: begin
          s = decide(s, ST_NO_A);
        end
      endcase
    end
  end

  assign nxt = s;

endmodule

[rtl/dns_response_parser.sv]
// DNS response parser. Feed the response payload one byte per transaction on
// in_ch, in network order, with last_byte set on the final byte. The parser
// accepts a byte on every clock while the result register is free or being
// drained, so the sustained rate is one byte per cycle; the combinational parse
// step behind the state register sets it. Exactly one result transaction
// (status, address) appears on out_ch for each final byte, in the cycle after
// it is accepted; address is zero unless status is 0 (found). Write
// expected_id through cfg_wr_en/cfg_wr_data before each response while the
// block is idle.
module dns_response_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  dnsrp_in_if.sink            in_ch,
  dnsrp_out_if.source         out_ch
);
  import dnsrp_pkg::*;

  parse_state_t state;
  parse_state_t state_next;
  logic [15:0]  expected_id;
  logic         out_valid;
  logic [3:0]   out_status;
  logic [31:0]  out_address;
  logic         in_ready;
  logic         in_accept;

  dnsrp_step u_step (
    .cur         (state),
    .rx_byte     (in_ch.rx_byte),
    .expected_id (expected_id),
    .nxt         (state_next)
  );

  assign in_ready  = !out_valid || out_ch.ready;
  assign in_accept = in_ch.valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= PARSE_CLEAR;
      expected_id <= 16'd0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) expected_id <= cfg_wr_data;
      if (out_ch.ready) out_valid <= 1'b0;
      if (in_accept) begin
        if (in_ch.last_byte) begin
          out_valid <= 1'b1;
          state     <= PARSE_CLEAR;
        end else begin
          state <= state_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_ch.last_byte) begin
      out_status  <= state_next.decided ? state_next.held_status : ST_NO_A;
      out_address <= (state_next.decided && state_next.held_status == ST_FOUND)
                     ? state_next.found_address : 32'd0;
    end
  end

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.status  = out_status;
  assign out_ch.address = out_address;

endmodule
